// File: rtl/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_PAD     = 7'h3D;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic [3:0][6:0] chars;
        logic            last;
    } t_job;

    function automatic logic [6:0] f_b64_char(input logic [5:0] v);
        logic [6:0] w;
        logic [6:0] r;
        w = {1'b0, v};
        if (v < 6'd26) begin
            r = CHAR_UPPER_A + w;
        end else if (v < 6'd52) begin
            r = CHAR_LOWER_A + w - 7'd26;
        end else if (v < 6'd62) begin
            r = CHAR_DIGIT_0 + w - 7'd52;
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/b64e_front.sv
`default_nettype none
module b64e_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire logic          i_q_full,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end_of_message,
    output b64e_pkg::t_job     o_job,
    output logic               o_wr_en
);
    import b64e_pkg::*;

    logic [3:0] r_pend;
    logic [1:0] r_phase;
    logic [3:0] n_pend;
    logic [1:0] n_phase;
    logic [3:0] pend_mid;
    logic [1:0] phase_mid;
    t_job       job;

    assign o_wr_en = push && !i_q_full;

    always_comb begin
        job       = '0;
        pend_mid  = '0;
        phase_mid = PH_FIRST;
        unique case (r_phase)
            PH_SECOND: begin
                job.chars[0] = f_b64_char({r_pend[1:0], i_data_byte[7:4]});
                pend_mid     = i_data_byte[3:0];
                phase_mid    = PH_THIRD;
            end
            PH_THIRD: begin
                job.chars[0] = f_b64_char({r_pend, i_data_byte[7:6]});
                job.chars[1] = f_b64_char(i_data_byte[5:0]);
                job.cnt_m1   = 2'd1;
                pend_mid     = '0;
                phase_mid    = PH_FIRST;
            end
            default: begin
                job.chars[0] = f_b64_char(i_data_byte[7:2]);
                pend_mid     = {2'b00, i_data_byte[1:0]};
                phase_mid    = PH_SECOND;
            end
        endcase
        n_pend  = pend_mid;
        n_phase = phase_mid;
        if (i_end_of_message) begin
            job.last = 1'b1;
            if (phase_mid == PH_SECOND) begin
                job.chars[1] = f_b64_char({pend_mid[1:0], 4'b0000});
                job.chars[2] = CHAR_PAD;
                job.chars[3] = CHAR_PAD;
                job.cnt_m1   = 2'd3;
            end else if (phase_mid == PH_THIRD) begin
                job.chars[1] = f_b64_char({pend_mid, 2'b00});
                job.chars[2] = CHAR_PAD;
                job.cnt_m1   = 2'd2;
            end
            n_pend  = '0;
            n_phase = PH_FIRST;
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_phase <= PH_FIRST;
        end else if (o_wr_en) begin
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

// File: rtl/b64e_jobq.sv
`default_nettype none
module b64e_jobq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire b64e_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_rd_en,
    output b64e_pkg::t_job     o_job,
    output logic               o_valid
);
    import b64e_pkg::*;

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wr_ptr;
    logic [JQ_AW-1:0] r_rd_ptr;
    logic [JQ_AW:0]   r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == (JQ_AW+1)'(JQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr      = i_wr_en && !o_full;
    assign rd      = i_rd_en && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + JQ_AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + JQ_AW'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + (JQ_AW+1)'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - (JQ_AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/b64e_back.sv
`default_nettype none
module b64e_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire b64e_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_done,
    output logic               empty,
    input  wire logic          pop,
    output logic [6:0]         o_ascii_char,
    output logic               o_last_char
);
    import b64e_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign empty        = !r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;
    assign load         = i_job_valid && (!r_out_valid || pop);
    assign at_end       = (r_idx == i_job.cnt_m1);
    assign o_job_done   = load && at_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_job.chars[r_idx];
            r_last <= i_job.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/base64_stream_encoder.sv
// path: a byte's characters pass through the job queue and then the output register
// throughput: one character per cycle while pop is held; a byte yields one or two characters,
// the last byte two to four (four characters per three bytes in a steady stream)
// the character serializer emitting one character per cycle while pop is held sets the rate
// a four-entry job queue lets bytes be taken while characters drain
// reset: synchronous, active low; clears group state, queue pointers and the output valid flag
`default_nettype none
module base64_stream_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_message,
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      o_ascii_char,
    output logic            o_last_char
);
    import b64e_pkg::*;

    t_job wr_job;
    t_job rd_job;
    logic wr_en;
    logic rd_valid;
    logic rd_done;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .i_q_full         (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_job            (wr_job),
        .o_wr_en          (wr_en)
    );

    b64e_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (wr_en),
        .i_job   (wr_job),
        .o_full  (full),
        .i_rd_en (rd_done),
        .o_job   (rd_job),
        .o_valid (rd_valid)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (rd_job),
        .i_job_valid  (rd_valid),
        .o_job_done   (rd_done),
        .empty        (empty),
        .pop          (pop),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule
`default_nettype wire
